// ===== rtl/arpc_pkg.sv =====
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared constants and types for the ARP responder with address cache.
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam int unsigned CACHE_ENTRIES = 16;
  localparam int unsigned IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(CACHE_ENTRIES + 1);

  localparam logic [15:0] MIN_FRAME_LEN  = 16'd42;
  localparam logic [15:0] HW_ETHERNET    = 16'h0001;
  localparam logic [15:0] PROTO_IPV4     = 16'h0800;
  localparam logic [15:0] OP_REQUEST     = 16'h0001;
  localparam logic [15:0] OP_REPLY       = 16'h0002;
  localparam logic [7:0]  HW_ADDR_LEN    = 8'h06;
  localparam logic [7:0]  PROTO_ADDR_LEN = 8'h04;

  // configuration register indexes
  localparam logic [1:0] REG_OWN_IP  = 2'd0;
  localparam logic [1:0] REG_OWN_MAC = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;

  // outcome codes
  typedef enum logic [2:0] {
    OUT_TICK      = 3'd0,
    OUT_SHORT     = 3'd1,
    OUT_BAD_FMT   = 3'd2,
    OUT_NOT_US    = 3'd3,
    OUT_ACCEPTED  = 3'd4,
    OUT_REPLIED   = 3'd5
  } outcome_t;

endpackage

// ===== rtl/arp_responder_with_cache_core.sv =====
// A packet that passes the checks is searched against the cache, one memory
// read per entry, then written back; a tick walks the entries the same way;
// a rejected packet goes straight to the result. One transaction at a time:
// a new packet is not accepted until the result has been taken. Reset clears
// valid bits, seconds counter and own IP/MAC registers; the timeout is set to 5.
// ----------------------------------------------------------------------------
// arp_responder_with_cache_core
// ARP packet check, RFC 826 merge, cache insert and aging, reply header.
// ----------------------------------------------------------------------------
module arp_responder_with_cache_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [15:0] frame_len,
  input  logic [15:0] hw_type,
  input  logic [15:0] proto_type,
  input  logic [7:0]  hw_len,
  input  logic [7:0]  proto_len,
  input  logic [15:0] opcode,
  input  logic [47:0] sender_mac,
  input  logic [31:0] sender_ip,
  input  logic [31:0] target_ip,
  output logic        out_valid,
  input  logic        out_stall,
  output arpc_pkg::outcome_t outcome,
  output logic        cache_merged,
  output logic        send_reply,
  output logic [15:0] reply_opcode,
  output logic [15:0] reply_hw_type,
  output logic [15:0] reply_proto_type,
  output logic [47:0] reply_sender_mac,
  output logic [31:0] reply_sender_ip,
  output logic [47:0] reply_target_mac,
  output logic [31:0] reply_target_ip
);
  import arpc_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_LAST  = 5'b00100,
    ST_WRITE = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  state_t state;

  // configuration registers
  logic [31:0] own_ip;
  logic [47:0] own_mac;
  logic [15:0] timeout_seconds;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_ip          <= '0;
      own_mac         <= '0;
      timeout_seconds <= 16'd5;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OWN_IP:  own_ip          <= cfg_data[31:0];
        REG_OWN_MAC: own_mac         <= cfg_data;
        REG_TIMEOUT: timeout_seconds <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // entry memories: ip and stamp are scanned, mac/proto written only
  logic [31:0] mem_ip    [CACHE_ENTRIES];
  logic [31:0] mem_stamp [CACHE_ENTRIES];
  logic [47:0] mem_mac   [CACHE_ENTRIES];
  logic [15:0] mem_proto [CACHE_ENTRIES];
  logic [CACHE_ENTRIES-1:0] valid;

  logic [31:0] rd_ip, rd_stamp;
  logic [IDX_W-1:0] rd_addr, rd_idx;
  logic [CNT_W-1:0] cnt;

  logic wr_en, wr_ins;
  logic [IDX_W-1:0] wr_addr;

  // transaction latched at acceptance
  logic        t_tick;
  logic [15:0] t_hw, t_proto, t_op;
  logic [47:0] t_mac;
  logic [31:0] t_sip, t_tip;
  logic [31:0] seconds_now;

  // scan results
  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic [IDX_W-1:0] old_idx;
  logic [31:0]      old_age;
  logic             old_seen;

  assign rd_addr = cnt[IDX_W-1:0];

  always_ff @(posedge clk) begin
    rd_ip    <= mem_ip[rd_addr];
    rd_stamp <= mem_stamp[rd_addr];
    rd_idx   <= rd_addr;
    if (wr_en) begin
      mem_mac[wr_addr]   <= t_mac;
      mem_stamp[wr_addr] <= seconds_now;
      if (wr_ins) begin
        mem_ip[wr_addr]    <= t_sip;
        mem_proto[wr_addr] <= t_proto;
      end
    end
  end

  logic accept_in, out_take, rd_live, fmt_bad, short_len;
  logic [31:0] age;
  assign in_stall  = (state != ST_IDLE);
  assign accept_in = in_valid && (state == ST_IDLE);
  assign out_take  = out_valid && !out_stall;
  assign short_len = frame_len < MIN_FRAME_LEN;
  assign fmt_bad   = (hw_type != HW_ETHERNET) || (hw_len != HW_ADDR_LEN) ||
                     (proto_type != PROTO_IPV4) || (proto_len != PROTO_ADDR_LEN);
  assign rd_live   = (state == ST_SCAN && cnt != '0) || state == ST_LAST;
  assign age       = seconds_now - rd_stamp;

  // write-back decision
  logic for_us;
  assign for_us = (t_tip == own_ip);
  always_comb begin
    wr_en   = 1'b0;
    wr_ins  = 1'b0;
    wr_addr = hit_idx;
    if (state == ST_WRITE && !t_tick) begin
      if (hit) begin
        wr_en = 1'b1;
      end else if (for_us) begin
        wr_en   = 1'b1;
        wr_ins  = 1'b1;
        wr_addr = free_found ? free_idx : old_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      valid       <= '0;
      seconds_now <= '0;
      out_valid   <= 1'b0;
      cnt         <= '0;
    end else begin
      if (out_take) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept_in) begin
            t_tick <= action; t_hw <= hw_type; t_proto <= proto_type;
            t_op <= opcode; t_mac <= sender_mac; t_sip <= sender_ip;
            t_tip <= target_ip;
            hit <= 1'b0; free_found <= 1'b0; old_seen <= 1'b0;
            hit_idx <= '0; free_idx <= '0; old_idx <= '0; old_age <= '0;
            cnt <= '0;
            outcome <= OUT_TICK; cache_merged <= 1'b0; send_reply <= 1'b0;
            reply_opcode <= '0; reply_hw_type <= '0; reply_proto_type <= '0;
            reply_sender_mac <= '0; reply_sender_ip <= '0;
            reply_target_mac <= '0; reply_target_ip <= '0;
            if (action) begin
              seconds_now <= seconds_now + 32'd1;
              state <= ST_SCAN;
            end else if (short_len) begin
              outcome <= OUT_SHORT; out_valid <= 1'b1; state <= ST_OUT;
            end else if (fmt_bad) begin
              outcome <= OUT_BAD_FMT; out_valid <= 1'b1; state <= ST_OUT;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN, ST_LAST: begin
          if (state == ST_SCAN) begin
            if (cnt == CNT_W'(CACHE_ENTRIES - 1)) state <= ST_LAST;
            else cnt <= cnt + CNT_W'(1);
          end else begin
            state <= ST_WRITE;
          end
          // examine the entry read in the previous cycle
          if (rd_live) begin
            if (t_tick) begin
              if (valid[rd_idx] && age > {16'd0, timeout_seconds})
                valid[rd_idx] <= 1'b0;
            end else begin
              if (valid[rd_idx] && rd_ip == t_sip && !hit) begin
                hit <= 1'b1; hit_idx <= rd_idx;
              end
              if (!valid[rd_idx] && !free_found) begin
                free_found <= 1'b1; free_idx <= rd_idx;
              end
              if (!old_seen || age > old_age) begin
                old_seen <= 1'b1; old_age <= age; old_idx <= rd_idx;
              end
            end
          end
        end
        ST_WRITE: begin
          if (wr_ins) valid[wr_addr] <= 1'b1;
          cache_merged <= !t_tick && hit;
          if (t_tick) outcome <= OUT_TICK;
          else if (!for_us) outcome <= OUT_NOT_US;
          else if (t_op != OP_REQUEST) outcome <= OUT_ACCEPTED;
          else begin
            outcome <= OUT_REPLIED; send_reply <= 1'b1;
            reply_opcode <= OP_REPLY; reply_hw_type <= t_hw;
            reply_proto_type <= t_proto; reply_sender_mac <= own_mac;
            reply_sender_ip <= own_ip; reply_target_mac <= t_mac;
            reply_target_ip <= t_sip;
          end
          out_valid <= 1'b1;
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_take) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
